// ----- rtl/idx_checkpoint_scanner_top_macros.svh -----
// Assertion macros shared by the scanner modules.
// Each expects signals named clk and rst_n in the module that uses it.
`ifndef IDX_CHECKPOINT_SCANNER_TOP_MACROS_SVH
`define IDX_CHECKPOINT_SCANNER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ICS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// ----- rtl/ics_pkg.sv -----
package ics_pkg;

    // Length of the trailer that follows the terminating zero of each word.
    localparam logic [3:0] TRAILER_BYTES = 4'd8;

    localparam logic [31:0] CHUNK_SIZE_RESET = 32'd4096;

    localparam int unsigned PADDR_W = 3;

    typedef enum logic
    {
        REG_CHUNK_SIZE = 1'b0
    } reg_idx_t;

    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       start_of_file;
    } in_item_t;

    typedef struct packed
    {
        logic [31:0] byte_offset;
        logic [31:0] entry_ordinal;
    } out_item_t;

endpackage

// ----- rtl/ics_obuf.sv -----
`include "idx_checkpoint_scanner_top_macros.svh"

// Two-entry result buffer: the scanner keeps running while one result waits.
module ics_obuf
    import ics_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // A full buffer still takes a result in the cycle its head leaves.
    assign room      = (count_reg != 2'd2) || out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ICS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= 2'd2)
    `ICS_ASSERT_SAME(a_no_overflow, push, (count_reg != 2'd2) || pop)
    `ICS_ASSERT_NEXT(a_ptr_gap, 1'b1,
        (wr_ptr_reg ^ rd_ptr_reg) == count_reg[0])

endmodule

// ----- rtl/idx_checkpoint_scanner_top.sv -----
// Checkpoint scanner for a dictionary index byte stream.
// The in channel takes one byte of the file per item; start_of_file marks the
// first byte of a new file, which restarts the scan and yields the item (0, 0).
// Each entry is a zero-terminated word and a fixed trailer; when an entry ends
// at or past the next checkpoint, the out channel gives the offset where the
// following entry starts and the number of entries completed so far.
// Users write chunk_size at APB address 0 only while idle; nothing enforces it.
// Throughput: one byte per cycle while the result buffer has room, set by the
// single scan stage, which updates the position, entry count and next
// checkpoint in the cycle the byte leaves the input register. A result is
// registered in the result buffer, from which the out channel offers it.
// A two-entry result buffer lets scanning carry on while the receiver stalls;
// once it is full and a byte waits in the input register, in_ready stays low
// until the receiver takes a result.
// Reset clears the scan state as if at a file start without emitting (0, 0),
// and sets chunk_size to 4096.
`include "idx_checkpoint_scanner_top_macros.svh"

module idx_checkpoint_scanner_top
    import ics_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] chunk_size_val_reg;
    reg_idx_t    reg_idx;

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;

    logic        in_word_reg;
    logic        in_word_next;
    logic [3:0]  trailer_left_reg;
    logic [3:0]  trailer_left_next;
    logic [31:0] file_position_reg;
    logic [31:0] file_position_next;
    logic [31:0] entries_done_reg;
    logic [31:0] entries_done_next;
    logic [31:0] next_mark_reg;
    logic [31:0] next_mark_next;

    logic        iw_cur;
    logic [3:0]  tl_cur;
    logic [31:0] pos_cur;
    logic [31:0] ent_cur;
    logic [31:0] mark_cur;
    logic [3:0]  tl_dec;
    logic [31:0] start_pos;
    logic [31:0] ent_inc;

    logic        buf_room;
    logic        fire;
    logic        emit;
    out_item_t   result;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_comb
    begin
        case (reg_idx)
            REG_CHUNK_SIZE: prdata = chunk_size_val_reg;
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_val_reg <= CHUNK_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_CHUNK_SIZE))
        begin
            chunk_size_val_reg <= pwdata;
        end
    end

    // Input register.
    assign fire     = s1_valid_reg && buf_room;
    assign in_ready = !s1_valid_reg || buf_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Scan stage. A file start first restores the reset state, with the next
    // checkpoint at chunk_size, then the byte is scanned as usual.
    always_comb
    begin
        iw_cur    = s1_item_reg.start_of_file ? 1'b1 : in_word_reg;
        tl_cur    = s1_item_reg.start_of_file ? 4'd0 : trailer_left_reg;
        pos_cur   = s1_item_reg.start_of_file ? 32'd0 : file_position_reg;
        ent_cur   = s1_item_reg.start_of_file ? 32'd0 : entries_done_reg;
        mark_cur  = s1_item_reg.start_of_file ? chunk_size_val_reg : next_mark_reg;
        tl_dec    = tl_cur - 4'd1;
        start_pos = pos_cur + 32'd1;
        ent_inc   = ent_cur + 32'd1;

        in_word_next       = iw_cur;
        trailer_left_next  = tl_cur;
        entries_done_next  = ent_cur;
        next_mark_next     = mark_cur;
        file_position_next = start_pos;
        emit               = s1_item_reg.start_of_file;
        result             = '0;

        if (iw_cur)
        begin
            if (s1_item_reg.data_byte == 8'h00)
            begin
                in_word_next      = 1'b0;
                trailer_left_next = TRAILER_BYTES;
            end
        end
        else
        begin
            trailer_left_next = tl_dec;
            if (tl_dec == 4'd0)
            begin
                entries_done_next = ent_inc;
                in_word_next      = 1'b1;
                if ((start_pos >= mark_cur) && !s1_item_reg.start_of_file)
                begin
                    emit                 = 1'b1;
                    result.byte_offset   = start_pos;
                    result.entry_ordinal = ent_inc;
                    next_mark_next       = start_pos + chunk_size_val_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg       <= 1'b1;
            trailer_left_reg  <= 4'd0;
            file_position_reg <= 32'd0;
            entries_done_reg  <= 32'd0;
            next_mark_reg     <= CHUNK_SIZE_RESET;
        end
        else if (fire)
        begin
            in_word_reg       <= in_word_next;
            trailer_left_reg  <= trailer_left_next;
            file_position_reg <= file_position_next;
            entries_done_reg  <= entries_done_next;
            next_mark_reg     <= next_mark_next;
        end
    end

    ics_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && emit),
        .push_item (result),
        .room      (buf_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `ICS_ASSERT_SAME(a_word_no_trailer, in_word_reg, trailer_left_reg == 4'd0)
    `ICS_ASSERT_NEXT(a_sof_emits, fire && s1_item_reg.start_of_file, out_valid)
    `ICS_ASSERT_NEXT(a_pos_step, fire && !s1_item_reg.start_of_file,
        file_position_reg == ($past(file_position_reg) + 32'd1))

endmodule

// ----- test/idx_checkpoint_scanner_top_tb.sv -----
module idx_checkpoint_scanner_top_tb;
    import ics_pkg::*;

    localparam logic [PADDR_W-1:0] CHUNK_ADDR = PADDR_W'(4 * int'(REG_CHUNK_SIZE));
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS = 10;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Scan state of the predictor.
    logic [31:0] chunk_cfg;
    logic [31:0] scan_pos;
    logic [31:0] entries_seen;
    logic [31:0] next_cp;
    logic [3:0]  trailer_cnt;
    logic        scan_in_word;

    out_item_t expected_marks[$];

    int bytes_sent = 0;
    int checkpoints_checked = 0;
    int mismatch_count = 0;
    int settings_used = 0;
    int burst_left = 0;
    int hold_off_cycles = 0;
    bit gaps_on = 1'b0;
    bit rx_steady = 1'b1;

    idx_checkpoint_scanner_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic restart_scan_model();
        scan_in_word = 1'b1;
        trailer_cnt = 4'd0;
        scan_pos = 32'd0;
        entries_seen = 32'd0;
        next_cp = chunk_cfg;
    endtask

    task automatic predict_checkpoint(input in_item_t it);
        out_item_t mark;
        logic [31:0] entry_start;
        bit emitted;
        emitted = 1'b0;
        mark = '0;
        if (it.start_of_file)
        begin
            restart_scan_model();
            emitted = 1'b1;
        end
        if (scan_in_word)
        begin
            if (it.data_byte == 8'h00)
            begin
                scan_in_word = 1'b0;
                trailer_cnt = TRAILER_BYTES;
            end
        end
        else
        begin
            trailer_cnt = trailer_cnt - 4'd1;
            if (trailer_cnt == 4'd0)
            begin
                entry_start = scan_pos + 32'd1;
                entries_seen = entries_seen + 32'd1;
                // A file start already produced this step's item.
                if (entry_start >= next_cp && !emitted)
                begin
                    mark.byte_offset = entry_start;
                    mark.entry_ordinal = entries_seen;
                    emitted = 1'b1;
                    next_cp = entry_start + chunk_cfg;
                end
                scan_in_word = 1'b1;
            end
        end
        scan_pos = scan_pos + 32'd1;
        if (emitted)
        begin
            expected_marks = {expected_marks, mark};
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof);
        in_item_t it;
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        it.data_byte = b;
        it.start_of_file = sof;
        in_item <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_checkpoint(it);
        bytes_sent++;
    endtask

    // Builds a run of well-formed entries; a broken file is cut off at a random byte.
    task automatic send_file(input int n_entries, input bit with_sof, input bit broken);
        logic [7:0] file_bytes[$];
        int n;
        for (int e = 0; e < n_entries; e++)
        begin
            repeat ($urandom_range(0, 5))
                file_bytes = {file_bytes, 8'($urandom_range(1, 255))};
            file_bytes = {file_bytes, 8'h00};
            repeat (TRAILER_BYTES)
                file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
        end
        n = broken ? $urandom_range(1, file_bytes.size() - 1) : file_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(file_bytes[i], with_sof && i == 0);
        end
    endtask

    // Stops offering items until every expected checkpoint has been taken, then lets
    // the pipeline empty of bytes that give no result.
    task automatic settle_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_marks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= CHUNK_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_chunk_size(input logic [31:0] value);
        logic [31:0] readback;
        settle_idle();
        apb_access(1'b1, value, readback);
        chunk_cfg = value;
        apb_access(1'b0, 32'd0, readback);
        if (readback !== value)
        begin
            note_mismatch($sformatf("chunk_size readback: expected %0d, got %0d",
                                    value, readback));
        end
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            checkpoints_checked++;
            if (expected_marks.size() == 0)
            begin
                note_mismatch($sformatf("unexpected checkpoint: offset=%0d ordinal=%0d",
                                        out_item.byte_offset, out_item.entry_ordinal));
            end
            else
            begin
                want = expected_marks.pop_front();
                if (out_item.byte_offset !== want.byte_offset
                    || out_item.entry_ordinal !== want.entry_ordinal)
                begin
                    note_mismatch($sformatf(
                        "checkpoint %0d: expected (%0d, %0d), got (%0d, %0d)",
                        checkpoints_checked, want.byte_offset, want.entry_ordinal,
                        out_item.byte_offset, out_item.entry_ordinal));
                end
            end
        end
    end

    // Receiver: alternating runs of ready and stall, unless held off or told to stay ready.
    initial
    begin : receiver
        bit rx_level;
        int rx_run;
        rx_level = 1'b1;
        rx_run = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (rx_steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                if (rx_run == 0)
                begin
                    rx_level = !rx_level;
                    rx_run = rx_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rx_run--;
                out_ready <= rx_level;
            end
        end
    end

    // After reset there is no file start: nothing may come out below the reset chunk size.
    task automatic test_reset_scan();
        logic [31:0] readback;
        gaps_on = 1'b0;
        rx_steady = 1'b1;
        apb_access(1'b0, 32'd0, readback);
        if (readback !== CHUNK_SIZE_RESET)
        begin
            note_mismatch($sformatf("chunk_size after reset: expected %0d, got %0d",
                                    CHUNK_SIZE_RESET, readback));
        end
        send_file(4, 1'b0, 1'b0);
        settle_idle();
    endtask

    // With a zero chunk size every completed entry is reported.
    task automatic test_zero_chunk_extremes();
        logic [8:0] seq[25] = '{
            {1'b1, 8'h00}, {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'h7F},
            {1'b0, 8'h01}, {1'b0, 8'hFE}, {1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b0, 8'hFF},
            {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00},
            {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h41},
            {1'b0, 8'h00}, {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b0, 8'h56}, {1'b1, 8'h00}
        };
        set_chunk_size(32'd0);
        rx_steady = 1'b0;
        foreach (seq[i])
        begin
            send_byte(seq[i][7:0], seq[i][8]);
        end
    endtask

    // The pending mark survives a register write; the new size applies from then on.
    task automatic test_chunk_change_mid_scan();
        set_chunk_size(32'hFFFF_FFFF);
        repeat (TRAILER_BYTES - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_file(2, 1'b0, 1'b0);
        send_file(3, 1'b1, 1'b0);
        set_chunk_size(32'hFFFF_FFF0);
        send_file(3, 1'b0, 1'b0);
        send_file(3, 1'b1, 1'b0);
    endtask

    // A long output stall fills the result buffer and must hold back the input.
    task automatic test_output_stall();
        set_chunk_size(32'd0);
        gaps_on = 1'b0;
        rx_steady = 1'b0;
        hold_off_cycles = 300;
        send_file(7, 1'b1, 1'b0);
        settle_idle();
    endtask

    task automatic test_random_files();
        logic [31:0] sizes[10] = '{32'd1, 32'd9, 32'd10, 32'd27, 32'd100, 32'd0,
                                   32'hFFFF_FFF0, 32'd4096, 32'd45, 32'd18};
        int goal;
        int pick;
        foreach (sizes[p])
        begin
            set_chunk_size(sizes[p]);
            gaps_on = (p % 3) != 0;
            rx_steady = (p % 4) == 1;
            goal = bytes_sent + 24;
            while (bytes_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    send_file($urandom_range(1, 8), 1'b1, 1'b0);
                end
                else if (pick < 90)
                begin
                    send_file($urandom_range(1, 5), 1'($urandom_range(0, 1)), 1'b1);
                end
                else if (pick < 96)
                begin
                    repeat ($urandom_range(4, 24))
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end
                else
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (expected_marks.size() != 0);
                end
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        chunk_cfg = CHUNK_SIZE_RESET;
        restart_scan_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scan();
        test_zero_chunk_extremes();
        test_chunk_change_mid_scan();
        test_output_stall();
        test_random_files();

        settle_idle();
        $display("Scanned %0d index bytes under %0d chunk sizes, %0d checkpoints compared.",
                 bytes_sent, settings_used, checkpoints_checked);
        $display("Mismatches: %0d, checkpoints still outstanding: %0d.",
                 mismatch_count, expected_marks.size());
        if (mismatch_count == 0 && expected_marks.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
